// ===== rtl/nmof_pkg.sv =====
// Package: widths, register codes, opcodes and shared types of the outlier filter.
`timescale 1ns / 1ps

package nmof_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAX_WIDTH = 256;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 9;
  localparam int HEIGHT_W  = 13;
  localparam int ROW_W     = 13;
  localparam int THRESH_W  = 16;
  localparam int SUM_W     = SAMPLE_W + 3;
  localparam int INDEX_W   = 2;
  localparam int DATA_W    = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 9'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 9'd256;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 9'd210;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 13'd420;
  localparam logic [THRESH_W-1:0] THRESH_RST   = 16'd1000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_t;

  // Line buffer control: write strobe, column written and column prefetched.
  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] wr_addr;
    logic [COL_W-1:0] rd_addr;
  } lb_ctrl_t;

endpackage

// ===== rtl/nmof_in_if.sv =====
// Interface: input channel carrying opcode and sample.
`timescale 1ns / 1ps

interface nmof_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  nmof_pkg::sample_t sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

// ===== rtl/nmof_out_if.sv =====
// Interface: output channel carrying the filtered pixel and its flags.
`timescale 1ns / 1ps

interface nmof_out_if;
  logic              valid;
  logic              ready;
  nmof_pkg::sample_t cleaned_sample;
  logic              replaced;
  logic              last_of_frame;

  modport source (output valid, output cleaned_sample, output replaced,
                  output last_of_frame, input ready);
  modport sink   (input valid, input cleaned_sample, input replaced,
                  input last_of_frame, output ready);
endinterface

// ===== rtl/nmof_line_buf.sv =====
// Two line stores with registered prefetch of the column about to be used.
`timescale 1ns / 1ps

module nmof_line_buf (
  input  logic               clk,
  input  nmof_pkg::lb_ctrl_t ctrl,
  input  nmof_pkg::sample_t  wr_data,
  output nmof_pkg::sample_t  top,
  output nmof_pkg::sample_t  mid
);

  nmof_pkg::sample_t upper_mem  [nmof_pkg::MAX_WIDTH];
  nmof_pkg::sample_t middle_mem [nmof_pkg::MAX_WIDTH];
  nmof_pkg::sample_t top_q;
  nmof_pkg::sample_t mid_q;
  logic              bypass;

  assign bypass = ctrl.we && (ctrl.wr_addr == ctrl.rd_addr);

  // mid_q holds middle[wr_addr] during a write, so the upper row takes it as is
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      upper_mem[ctrl.wr_addr]  <= mid_q;
      middle_mem[ctrl.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (bypass) begin
      top_q <= mid_q;
      mid_q <= wr_data;
    end else begin
      top_q <= upper_mem[ctrl.rd_addr];
      mid_q <= middle_mem[ctrl.rd_addr];
    end
  end

  assign top = top_q;
  assign mid = mid_q;

endmodule

// ===== rtl/neighbor_mean_outlier_filter.sv =====
// Top level: 3x3 neighbour-mean outlier filter over a streamed raster.
//
//   channel   direction  handshake          payload
//   pix_in    sink       valid/ready        opcode, sample
//   pix_out   source     valid/ready        cleaned_sample, replaced, last_of_frame
//   config    write      wr_en              wr_index, wr_data
//
// One item per clock while the result register is not stalled; a result passes the window
// register, then the result register, after its completing transaction.
// The line stores are read one column ahead, so a single-port read per cycle keeps pace.
// Reset is synchronous: geometry and threshold return to defaults, position to frame start.
// A stalled result register holds the window stage; input ready drops only then.
`timescale 1ns / 1ps

module neighbor_mean_outlier_filter (
  input  logic                          clk,
  input  logic                          rst,
  nmof_in_if.sink                       pix_in,
  nmof_out_if.source                    pix_out,
  input  logic                          wr_en,
  input  logic [nmof_pkg::INDEX_W-1:0]  wr_index,
  input  logic [nmof_pkg::DATA_W-1:0]   wr_data
);

  // configuration
  logic [nmof_pkg::WIDTH_W-1:0]  eff_w;
  logic [nmof_pkg::HEIGHT_W-1:0] eff_h;
  logic [nmof_pkg::THRESH_W-1:0] threshold;
  logic [nmof_pkg::WIDTH_W-1:0]  w_wr;
  logic [nmof_pkg::HEIGHT_W-1:0] h_wr;
  logic                          geom_wr;

  // position
  logic [nmof_pkg::COL_W-1:0] col, col_next;
  logic [nmof_pkg::ROW_W-1:0] row, row_next;

  // input side
  logic              accept, step, tail, col_last, is_last, res_valid, interior;
  nmof_pkg::sample_t v, lb_top, lb_mid;
  nmof_pkg::lb_ctrl_t lb_ctrl;

  // window stage
  nmof_pkg::sample_t win [3][3];
  logic              a_valid, a_interior, a_last;
  logic              a_free, b_free;

  // result stage
  logic                           out_valid;
  nmof_pkg::sample_t              out_sample;
  logic                           out_repl, out_last;
  logic signed [nmof_pkg::SUM_W-1:0] sum, sum_rnd;
  nmof_pkg::sample_t              mean;
  logic signed [nmof_pkg::SAMPLE_W:0] diff;
  logic [nmof_pkg::SAMPLE_W:0]    abs_diff;
  logic                           repl;

  // ---------------- configuration ----------------
  always_comb begin
    w_wr = wr_data[nmof_pkg::WIDTH_W-1:0];
    if (w_wr < nmof_pkg::WIDTH_MIN) w_wr = nmof_pkg::WIDTH_MIN;
    else if (w_wr > nmof_pkg::WIDTH_MAX) w_wr = nmof_pkg::WIDTH_MAX;
    h_wr = wr_data[nmof_pkg::HEIGHT_W-1:0];
    if (h_wr < nmof_pkg::HEIGHT_MIN) h_wr = nmof_pkg::HEIGHT_MIN;
    else if (h_wr > nmof_pkg::HEIGHT_MAX) h_wr = nmof_pkg::HEIGHT_MAX;
  end

  assign geom_wr = wr_en && (wr_index == nmof_pkg::REG_FRAME_WIDTH ||
                             wr_index == nmof_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w     <= nmof_pkg::WIDTH_RST;
      eff_h     <= nmof_pkg::HEIGHT_RST;
      threshold <= nmof_pkg::THRESH_RST;
    end else if (wr_en) begin
      case (wr_index)
        nmof_pkg::REG_FRAME_WIDTH:  eff_w     <= w_wr;
        nmof_pkg::REG_FRAME_HEIGHT: eff_h     <= h_wr;
        nmof_pkg::REG_THRESHOLD:    threshold <= wr_data[nmof_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- position and line stores ----------------
  assign b_free       = !out_valid || pix_out.ready;
  assign a_free       = !a_valid || b_free;
  assign pix_in.ready = a_free;

  assign accept = pix_in.valid && pix_in.ready;
  assign tail   = row >= eff_h;
  // drop a flush that arrives before the frame is complete
  assign step   = accept && !(pix_in.opcode == nmof_pkg::OP_FLUSH && !tail);
  assign v      = tail ? '0 : pix_in.sample;

  assign col_last  = ({1'b0, col} + 9'd1) == eff_w;
  assign is_last   = (col == '0) && (row > eff_h);
  assign res_valid = (col != '0) ? (row != '0) : (row >= 13'd2);
  assign interior  = (col >= 8'd2) && (row >= 13'd2) && (row < eff_h);

  always_comb begin
    col_next = col;
    row_next = row;
    if (geom_wr) begin
      col_next = '0;
      row_next = '0;
    end else if (step) begin
      if (is_last) begin
        col_next = '0;
        row_next = '0;
      end else if (col_last) begin
        col_next = '0;
        row_next = row + 13'd1;
      end else begin
        col_next = col + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign lb_ctrl.we      = step;
  assign lb_ctrl.wr_addr = col;
  assign lb_ctrl.rd_addr = col_next;

  nmof_line_buf u_line_buf (
    .clk     (clk),
    .ctrl    (lb_ctrl),
    .wr_data (v),
    .top     (lb_top),
    .mid     (lb_mid)
  );

  // ---------------- window stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (step) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= lb_top;
      win[1][2] <= lb_mid;
      win[2][2] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (step) begin
      a_valid <= res_valid;
    end else if (b_free) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      a_interior <= interior;
      a_last     <= is_last;
    end
  end

  // ---------------- mean, compare and result register ----------------
  always_comb begin
    sum = SUM_W'(win[0][0]) + SUM_W'(win[0][1]) + SUM_W'(win[0][2])
        + SUM_W'(win[1][0])                      + SUM_W'(win[1][2])
        + SUM_W'(win[2][0]) + SUM_W'(win[2][1]) + SUM_W'(win[2][2]);
    // half away from zero: add 4 for positive sums, 3 for negative, then floor
    sum_rnd  = sum + (sum[nmof_pkg::SUM_W-1] ? 19'sd3 : 19'sd4);
    mean     = nmof_pkg::sample_t'(sum_rnd >>> 3);
    diff     = {win[1][1][nmof_pkg::SAMPLE_W-1], win[1][1]}
             - {mean[nmof_pkg::SAMPLE_W-1], mean};
    abs_diff = diff[nmof_pkg::SAMPLE_W] ? 17'(-diff) : 17'(diff);
    repl     = a_interior && (abs_diff > {1'b0, threshold});
  end

  localparam int SUM_W = nmof_pkg::SUM_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_free) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid) begin
      out_sample <= repl ? mean : win[1][1];
      out_repl   <= repl;
      out_last   <= a_last;
    end
  end

  assign pix_out.valid          = out_valid;
  assign pix_out.cleaned_sample = out_sample;
  assign pix_out.replaced       = out_repl;
  assign pix_out.last_of_frame  = out_last;

  // ---------------- assertions ----------------
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < eff_w)
    else $error("column position beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row} <= ({1'b0, eff_h} + 14'd1))
    else $error("row position beyond frame tail");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    step && is_last && !geom_wr |=> (row == '0) && (col == '0))
    else $error("position not returned to frame start after last pixel");

  a_corner_kept: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.last_of_frame |-> !pix_out.replaced)
    else $error("border pixel replaced at frame end");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> pix_out.valid && !pix_out.ready)
    else $error("input held off without a stalled result");

endmodule

// ===== sim/tb_neighbor_mean_outlier_filter.sv =====
// Testbench: random-stall stream test of the 3x3 neighbour-mean outlier filter against a predictor.
`timescale 1ns / 1ps

module tb_neighbor_mean_outlier_filter;
  import nmof_pkg::*;

  localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam sample_t SAMPLE_HI     = 16'sh7FFF;
  localparam sample_t SAMPLE_LO     = 16'sh8000;
  localparam int      SETTLE_CYCLES = 6;
  localparam int      RANDOM_ITEMS  = 400;

  typedef struct packed {
    sample_t cleaned;
    logic    replaced;
    logic    last;
  } filtered_pixel_t;

  class pixel_scoreboard;
    int unsigned     width_reg, height_reg, thresh_reg;
    sample_t         upper_line [MAX_WIDTH];
    sample_t         middle_line [MAX_WIDTH];
    sample_t         win [3][3];
    int unsigned     col, row;
    filtered_pixel_t pixels_due [$];
    int              mismatches;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      thresh_reg = THRESH_RST;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col        = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    function int unsigned frame_cols();
      if (width_reg < WIDTH_MIN) return WIDTH_MIN;
      if (width_reg > WIDTH_MAX) return WIDTH_MAX;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      if (height_reg < HEIGHT_MIN) return HEIGHT_MIN;
      if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
      return height_reg;
    endfunction

    function void write_register(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = data[WIDTH_W-1:0];
          col = 0;
          row = 0;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data[HEIGHT_W-1:0];
          col = 0;
          row = 0;
        end
        REG_THRESHOLD: thresh_reg = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_pixel(input opcode_t op, input sample_t smp);
      int unsigned     w, h, r, c, orow, ocol;
      bit              tail, due;
      sample_t         v, top, mid;
      int              total, mean, diff;
      filtered_pixel_t px;
      w    = frame_cols();
      h    = frame_rows();
      r    = row;
      c    = col;
      tail = (r >= h);
      // drop a flush that arrives before the frame is complete
      if (op == OP_FLUSH && !tail) return;
      if (c >= w) c = 0;
      v   = tail ? sample_t'(0) : smp;
      top = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = v;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = v;

      if (c >= 1) begin
        due  = (r >= 1);
        orow = r - 1;
        ocol = c - 1;
      end else begin
        due  = (r >= 2);
        orow = r - 2;
        ocol = w - 1;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
      if (!due) return;

      px.cleaned  = win[1][1];
      px.replaced = 1'b0;
      if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
        total = 0;
        foreach (win[i, j]) if (!(i == 1 && j == 1)) total += win[i][j];
        // divide by 8, rounding half away from zero
        mean = ((total < 0 ? -total : total) + 4) >> 3;
        if (total < 0) mean = -mean;
        diff = int'(win[1][1]) - mean;
        if (diff < 0) diff = -diff;
        if (longint'(diff) > longint'(thresh_reg)) begin
          px.cleaned  = sample_t'(mean);
          px.replaced = 1'b1;
        end
      end
      px.last = (orow >= h - 1) && (ocol == w - 1);
      if (px.last) begin
        col = 0;
        row = 0;
      end
      pixels_due.push_back(px);
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("%0t ns  mismatch: %s", $time, what);
    endtask

    task check_cleaned_pixel(input filtered_pixel_t got);
      filtered_pixel_t want;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, cleaned_sample %0d", got.cleaned));
        return;
      end
      want = pixels_due.pop_front();
      if (got.cleaned !== want.cleaned)
        report_mismatch($sformatf("cleaned_sample %0d, expected %0d", got.cleaned, want.cleaned));
      if (got.replaced !== want.replaced)
        report_mismatch($sformatf("replaced %b, expected %b", got.replaced, want.replaced));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_of_frame %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [DATA_W-1:0]  wr_data;
  bit                 steady;
  int                 hold_request;
  int                 counted_items;
  pixel_scoreboard    sb;

  nmof_in_if  pix_in_ch ();
  nmof_out_if pix_out_ch ();

  neighbor_mean_outlier_filter DUT (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_ch),
    .pix_out (pix_out_ch),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor both channels on the edge that completes each transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_in_ch.valid && pix_in_ch.ready)
        sb.predict_pixel(opcode_t'(pix_in_ch.opcode), pix_in_ch.sample);
      if (pix_out_ch.valid && pix_out_ch.ready)
        sb.check_cleaned_pixel(filtered_pixel_t'{pix_out_ch.cleaned_sample,
                                                 pix_out_ch.replaced,
                                                 pix_out_ch.last_of_frame});
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    pix_out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        pix_out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        pix_out_ch.ready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic send_item(input opcode_t op, input sample_t smp);
    if (!steady && $urandom_range(99) < 11) begin
      pix_in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pix_in_ch.valid  <= 1'b1;
    pix_in_ch.opcode <= op;
    pix_in_ch.sample <= smp;
    do @(posedge clk); while (pix_in_ch.ready !== 1'b1);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the input until every expected result is out, then let the pipeline settle
  task automatic drain(input int settle);
    pix_in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pixels_due.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned sample_cap, input int pause_at,
                            output bit cut_short);
    int unsigned w, n;
    int          base, sel, v;
    w    = sb.frame_cols();
    n    = w * sb.frame_rows();
    base = int'($urandom_range(0, 60000)) - 30000;
    cut_short = (sample_cap < n);
    for (int unsigned i = 0; i < n && i < sample_cap; i++) begin
      if (int'(i) == pause_at) drain(0);
      // stray flush inside the frame: ignored by the block
      if ($urandom_range(99) < 4) send_item(OP_FLUSH, sample_t'($urandom_range(0, 65535)));
      sel = $urandom_range(99);
      if (sel < 60)
        v = base + int'($urandom_range(0, 400)) - 200;
      else if (sel < 80)
        v = ($urandom_range(1) != 0) ? base + int'($urandom_range(500, 20000))
                                     : base - int'($urandom_range(500, 20000));
      else
        v = int'($urandom_range(0, 65535));
      send_item(OP_SAMPLE, sample_t'(v));
      counted_items++;
    end
    if (cut_short) return;
    // tail of W+1 items; a sample here counts as a flush
    for (int unsigned k = 0; k <= w; k++) begin
      send_item(($urandom_range(3) == 0) ? OP_SAMPLE : OP_FLUSH,
                sample_t'($urandom_range(0, 65535)));
      counted_items++;
    end
    if ($urandom_range(99) < 20) send_item(OP_FLUSH, '0);
  endtask

  initial begin
    bit          cut_short;
    int unsigned n;
    int          sel;
    sb = new();
    rst              = 1'b1;
    wr_en            = 1'b0;
    wr_index         = '0;
    wr_data          = '0;
    pix_in_ch.valid  = 1'b0;
    pix_in_ch.opcode = OP_SAMPLE;
    pix_in_ch.sample = '0;
    steady           = 1'b0;
    hold_request     = 0;
    counted_items    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest frame, full-scale samples: centre differs by exactly the maximum threshold
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hA5A5);
    send_item(OP_FLUSH, SAMPLE_LO);
    for (int i = 0; i < 9; i++) send_item(OP_SAMPLE, (i == 4) ? SAMPLE_LO : SAMPLE_HI);
    send_item(OP_FLUSH, '0);
    send_item(OP_SAMPLE, 16'sh1234);
    send_item(OP_FLUSH, SAMPLE_HI);
    send_item(OP_FLUSH, '0);
    drain(SETTLE_CYCLES);

    // Geometry below the minimum clamps to 3x3; neighbours sum to -12, mean -1.5 -> -2
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_THRESHOLD, 0);
    for (int i = 0; i < 9; i++)
      send_item(OP_SAMPLE, (i == 4) ? sample_t'(5) : ((i % 2) ? sample_t'(-2) : sample_t'(-1)));
    repeat (4) send_item(OP_FLUSH, '0);
    send_item(OP_FLUSH, '0);
    drain(SETTLE_CYCLES);

    // Full-width frame with neither side idling
    write_reg(REG_FRAME_WIDTH, 256);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_THRESHOLD, 150);
    steady = 1'b1;
    send_frame(768, -1, cut_short);
    steady = 1'b0;
    drain(SETTLE_CYCLES);

    // Oversized geometry clamps to the maxima; run only the top of the frame
    write_reg(REG_FRAME_WIDTH, 16'h01FF);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    send_frame(600, -1, cut_short);
    drain(SETTLE_CYCLES);
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 4096);
    send_frame(40, -1, cut_short);
    drain(SETTLE_CYCLES);

    counted_items = 0;
    for (int phase = 0; counted_items < RANDOM_ITEMS; phase++) begin
      // a cut frame leaves the position mid-frame: restart it with a geometry write
      if (cut_short || $urandom_range(99) < 70) begin
        sel = $urandom_range(99);
        write_reg(REG_FRAME_WIDTH, (sel < 8) ? $urandom_range(0, 2) :
                                   (sel < 16) ? 3 : $urandom_range(4, 12));
        sel = $urandom_range(99);
        write_reg(REG_FRAME_HEIGHT, (sel < 8) ? $urandom_range(0, 2) :
                                    (sel < 16) ? 3 : $urandom_range(4, 7));
      end
      if ($urandom_range(99) < 50) begin
        sel = $urandom_range(99);
        write_reg(REG_THRESHOLD, (sel < 10) ? 0 : (sel < 20) ? 16'hFFFF :
                                 (sel < 70) ? $urandom_range(0, 400) : $urandom_range(0, 65535));
      end
      if ($urandom_range(99) < 10) write_reg(REG_UNUSED, $urandom_range(0, 65535));
      n = sb.frame_cols() * sb.frame_rows();
      if (phase == 0) hold_request = 200;
      send_frame((phase < 2 || $urandom_range(99) >= 12) ? n : $urandom_range(1, n - 1),
                 (phase == 1) ? int'(n / 2) : -1, cut_short);
      drain(SETTLE_CYCLES);
    end

    drain(2 * SETTLE_CYCLES);
    if (sb.mismatches == 0)
      $display("tb_neighbor_mean_outlier_filter: PASS");
    else
      $display("tb_neighbor_mean_outlier_filter: FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_neighbor_mean_outlier_filter: FAIL");
    $finish;
  end

endmodule
